// ===== hdl/torus_xy_route_walker_assert.svh =====
// Assertion macros for the route walker RTL.
// Each macro expands to one labeled concurrent assertion, clocked on clk,
// held off while rst is high.
`ifndef TORUS_XY_ROUTE_WALKER_ASSERT_SVH
`define TORUS_XY_ROUTE_WALKER_ASSERT_SVH

// Same-cycle implication.
`define TRXW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TRXW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/trxw_pkg.sv =====
//==============================================================================
// trxw_pkg
// Types, constants and the microcode program of the torus XY route walker.
//==============================================================================
package trxw_pkg;

  localparam int ID_W        = 8;   // linear node id
  localparam int RING_W      = 5;   // ring size register
  localparam int NODE_W      = 2 * RING_W;
  localparam int MAX_RESULTS = 16;  // hops emitted per route at most
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int PC_W        = 3;

  localparam logic [RING_W-1:0] RING_RESET = RING_W'(4);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RING_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_HEIGHT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0] source_node;
    logic [ID_W-1:0] target_node;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] hop_from;
    logic [ID_W-1:0] hop_to;
    logic            final_hop;
  } hop_t;

  // Datapath action of one microcode step
  typedef enum logic [2:0] {
    OP_IDLE,   // wait for a request, capture it
    OP_START,  // check the route, load the dividers
    OP_DIV,    // one quotient bit per cycle
    OP_XSET,   // set up the row leg
    OP_XHOP,   // emit one hop along the row
    OP_YSET,   // set up the column leg
    OP_YHOP,   // emit one hop along the column
    OP_NONE
  } op_t;

  // Branch condition of one microcode step
  typedef enum logic [2:0] {
    COND_WAIT_REQ,  // hold until a request beat lands
    COND_BAD,       // jump when the route is empty
    COND_DIV,       // hold until the dividers finish
    COND_X_EQ,      // jump when no row leg is needed
    COND_Y_EQ,      // jump when no column leg is needed
    COND_HOP,       // hold while the leg runs, step on at the leg's end, jump on the final hop
    COND_GOTO       // jump always
  } cond_t;

  localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] STEP_CHECK = 3'd1;
  localparam logic [PC_W-1:0] STEP_DIV   = 3'd2;
  localparam logic [PC_W-1:0] STEP_XSET  = 3'd3;
  localparam logic [PC_W-1:0] STEP_XHOP  = 3'd4;
  localparam logic [PC_W-1:0] STEP_YSET  = 3'd5;
  localparam logic [PC_W-1:0] STEP_YHOP  = 3'd6;
  localparam logic [PC_W-1:0] STEP_END   = 3'd7;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic req_fire;
    logic route_bad;
    logic div_done;
    logic x_equal;
    logic y_equal;
    logic slot_free;
    logic hop_last;
    logic seg_end;
  } status_t;

  // Control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      STEP_IDLE:  w = '{op: OP_IDLE,  cond: COND_WAIT_REQ, target: STEP_IDLE};
      STEP_CHECK: w = '{op: OP_START, cond: COND_BAD,      target: STEP_IDLE};
      STEP_DIV:   w = '{op: OP_DIV,   cond: COND_DIV,      target: STEP_IDLE};
      STEP_XSET:  w = '{op: OP_XSET,  cond: COND_X_EQ,     target: STEP_YSET};
      STEP_XHOP:  w = '{op: OP_XHOP,  cond: COND_HOP,      target: STEP_IDLE};
      STEP_YSET:  w = '{op: OP_YSET,  cond: COND_Y_EQ,     target: STEP_IDLE};
      STEP_YHOP:  w = '{op: OP_YHOP,  cond: COND_HOP,      target: STEP_IDLE};
      STEP_END:   w = '{op: OP_NONE,  cond: COND_GOTO,     target: STEP_IDLE};
      default:    w = '{op: OP_NONE,  cond: COND_GOTO,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/trxw_div.sv =====
//==============================================================================
// trxw_div
// Two-lane restoring divider, one quotient bit per cycle while step is high, shared divisor.
//==============================================================================
module trxw_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          step,
  input  logic [trxw_pkg::ID_W-1:0]     dividend [2],
  input  logic [trxw_pkg::RING_W-1:0]   divisor,
  output logic [trxw_pkg::ID_W-1:0]     quot [2],
  output logic [trxw_pkg::RING_W-1:0]   rem [2],
  output logic                          done
);

  localparam int STEP_CNT_W = $clog2(trxw_pkg::ID_W + 1);

  logic [STEP_CNT_W-1:0]       count;
  logic [trxw_pkg::ID_W-1:0]   num [2];
  logic [trxw_pkg::RING_W-1:0] part [2];
  logic [trxw_pkg::RING_W:0]   trial [2];
  logic                        fits [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i] = {part[i], num[i][trxw_pkg::ID_W-1]};
      fits[i]  = (trial[i] >= {1'b0, divisor});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= STEP_CNT_W'(trxw_pkg::ID_W);
    end else if (step && (count != '0)) begin
      count <= count - 1'b1;
    end
  end

  // Quotient bits shift into the dividend register from the bottom
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (start) begin
        num[i]  <= dividend[i];
        part[i] <= '0;
      end else if (step && (count != '0)) begin
        num[i] <= {num[i][trxw_pkg::ID_W-2:0], fits[i]};
        if (fits[i]) begin
          part[i] <= trxw_pkg::RING_W'(trial[i] - {1'b0, divisor});
        end else begin
          part[i] <= trial[i][trxw_pkg::RING_W-1:0];
        end
      end
    end
  end

  assign done = (count == '0);
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      quot[i] = num[i];
      rem[i]  = part[i];
    end
  end

endmodule

// ===== hdl/trxw_seq.sv =====
//==============================================================================
// trxw_seq
// Microcode sequencer: step counter, control store lookup, branch logic.
//==============================================================================
module trxw_seq (
  input  logic              clk,
  input  logic              rst,
  input  trxw_pkg::status_t status,
  output trxw_pkg::ctrl_t   ctrl
);

  logic [trxw_pkg::PC_W-1:0] pc;
  logic [trxw_pkg::PC_W-1:0] pc_next;

  assign ctrl = trxw_pkg::ucode(pc);

  always_comb begin
    case (ctrl.cond)
      trxw_pkg::COND_WAIT_REQ: pc_next = status.req_fire ? pc + 1'b1 : pc;
      trxw_pkg::COND_BAD:      pc_next = status.route_bad ? ctrl.target : pc + 1'b1;
      trxw_pkg::COND_DIV:      pc_next = status.div_done ? pc + 1'b1 : pc;
      trxw_pkg::COND_X_EQ:     pc_next = status.x_equal ? ctrl.target : pc + 1'b1;
      trxw_pkg::COND_Y_EQ:     pc_next = status.y_equal ? ctrl.target : pc + 1'b1;
      trxw_pkg::COND_HOP: begin
        if (!status.slot_free) begin
          pc_next = pc;
        end else if (status.hop_last) begin
          pc_next = ctrl.target;
        end else if (status.seg_end) begin
          pc_next = pc + 1'b1;
        end else begin
          pc_next = pc;
        end
      end
      trxw_pkg::COND_GOTO:     pc_next = ctrl.target;
      default:                 pc_next = trxw_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= trxw_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== hdl/torus_xy_route_walker.sv =====
//==============================================================================
// torus_xy_route_walker
// Dimension-order route walker for a 2D torus: one hop beat per link used,
// row leg first, then column leg, shorter way round each ring.
//==============================================================================
//
//  channel | dir | beat                              | handshake
//  --------+-----+-----------------------------------+------------------------
//  req     | in  | source_node, target_node          | req_valid / req_stall
//  hop     | out | hop_from, hop_to, final_hop       | hop_valid / hop_stall
//  cfg     | in  | cfg_index, cfg_data               | cfg_we, no wait
//
//  Steps: a request is accepted at idle and checked, then a shift-subtract
//  division by ring_width (eight quotient steps) splits both ids into row and
//  column, then the row leg is set up and walked, then the column leg; a leg
//  that is not needed is skipped. A request with an empty route goes from the
//  check straight back to idle. A route has at most 16 hops. Within a leg one
//  hop beat leaves per cycle while the hop side does not stall; a stalled beat
//  holds the walk until it is taken.
//  Reset: ring_width and ring_height return to 4, the sequencer to idle and the
//  hop register to empty. No memory to clear.
//  req_stall is high after accept until the last hop loads or the check fails.
//
module torus_xy_route_walker #(
  parameter int MAX_SIDE = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  trxw_pkg::req_t                   req,
  output logic                             hop_valid,
  input  logic                             hop_stall,
  output trxw_pkg::hop_t                   hop,
  input  logic                             cfg_we,
  input  logic [trxw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trxw_pkg::RING_W-1:0]      cfg_data
);

  `include "torus_xy_route_walker_assert.svh"

  localparam int RW = trxw_pkg::RING_W;
  localparam int IW = trxw_pkg::ID_W;
  // Ring coordinates stay below MAX_SIDE and below the 5-bit ring register
  localparam int COORD_W = ($clog2(MAX_SIDE) < RW) ? $clog2(MAX_SIDE) : RW;
  localparam int PROD_W  = COORD_W + RW;

  // Configuration
  logic [RW-1:0] ring_width;
  logic [RW-1:0] ring_height;

  // Captured request
  logic [IW-1:0] source_node;
  logic [IW-1:0] target_node;

  // Sequencer interface
  trxw_pkg::ctrl_t   ctrl;
  trxw_pkg::status_t status;

  // Divider interface
  logic [IW-1:0] div_dividend [2];
  logic [IW-1:0] div_quot [2];
  logic [RW-1:0] div_rem [2];
  logic          div_done;

  // Walk state
  logic [COORD_W-1:0]         cur;
  logic                       fwd;
  logic [IW-1:0]              row_base;
  logic [trxw_pkg::CNT_W-1:0] hop_count;

  // Datapath wires
  logic                  req_fire;
  logic                  route_bad;
  logic [trxw_pkg::NODE_W-1:0] node_count;
  logic [COORD_W-1:0]    srow, scol, drow, dcol;
  logic                  y_phase;
  logic [RW-1:0]         ring_len;
  logic [RW-1:0]         ring_m1;
  logic [COORD_W-1:0]    end_coord;
  logic [RW:0]           cur_inc;
  logic [COORD_W-1:0]    nxt;
  logic                  seg_end;
  logic                  hop_last;
  logic                  slot_free;
  logic                  emit;
  logic [PROD_W-1:0]     srow_prod;
  logic [PROD_W-1:0]     cur_prod;
  logic [PROD_W-1:0]     nxt_prod;
  logic [IW-1:0]         from_id;
  logic [IW-1:0]         to_id;

  // Forward if forward distance <= half the ring; a tie goes forward if a < b
  function automatic logic dir_fwd(input logic [COORD_W-1:0] a,
                                   input logic [COORD_W-1:0] b,
                                   input logic [RW-1:0]      half);
    logic [COORD_W-1:0] diff;
    logic [RW-1:0]      gap;
    diff = (a < b) ? (b - a) : (a - b);
    gap  = RW'(diff);
    return (a < b) ? (gap <= half) : !(gap <= half);
  endfunction

  //----------------------------------------------------------------------------
  // Configuration registers
  //----------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_width  <= trxw_pkg::RING_RESET;
      ring_height <= trxw_pkg::RING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        trxw_pkg::REG_RING_WIDTH:  ring_width  <= cfg_data;
        trxw_pkg::REG_RING_HEIGHT: ring_height <= cfg_data;
        default: ;
      endcase
    end
  end

  //----------------------------------------------------------------------------
  // Request side: take a beat only while the program sits at idle
  //----------------------------------------------------------------------------
  assign req_stall = rst || (ctrl.op != trxw_pkg::OP_IDLE);
  assign req_fire  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (req_fire) begin
      source_node <= req.source_node;
      target_node <= req.target_node;
    end
  end

  // Empty route: bad ring size, id outside the torus, or same node
  assign node_count = {{RW{1'b0}}, ring_width} * {{RW{1'b0}}, ring_height};
  assign route_bad  = (ring_width == '0) || (ring_height == '0)
                   || (int'(ring_width) > MAX_SIDE) || (int'(ring_height) > MAX_SIDE)
                   || (trxw_pkg::NODE_W'(source_node) >= node_count)
                   || (trxw_pkg::NODE_W'(target_node) >= node_count)
                   || (source_node == target_node);

  //----------------------------------------------------------------------------
  // Split both ids into row and column
  //----------------------------------------------------------------------------
  assign div_dividend[0] = source_node;
  assign div_dividend[1] = target_node;

  trxw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.op == trxw_pkg::OP_START),
    .step     (ctrl.op == trxw_pkg::OP_DIV),
    .dividend (div_dividend),
    .divisor  (ring_width),
    .quot     (div_quot),
    .rem      (div_rem),
    .done     (div_done)
  );

  // Quotient and remainder hold after the division until the next request
  assign srow = div_quot[0][COORD_W-1:0];
  assign scol = div_rem[0][COORD_W-1:0];
  assign drow = div_quot[1][COORD_W-1:0];
  assign dcol = div_rem[1][COORD_W-1:0];

  //----------------------------------------------------------------------------
  // Ring step: one index forward or back, wrap at the ends
  //----------------------------------------------------------------------------
  assign y_phase   = (ctrl.op == trxw_pkg::OP_YHOP);
  assign ring_len  = y_phase ? ring_height : ring_width;
  assign end_coord = y_phase ? drow : dcol;
  assign ring_m1   = ring_len - 1'b1;
  assign cur_inc   = (RW + 1)'(cur) + 1'b1;

  always_comb begin
    if (fwd) begin
      nxt = (cur_inc >= {1'b0, ring_len}) ? '0 : cur_inc[COORD_W-1:0];
    end else begin
      nxt = (cur == '0) ? ring_m1[COORD_W-1:0] : cur - 1'b1;
    end
  end

  assign seg_end  = (nxt == end_coord);
  // Final hop: end of the column leg, end of the row leg with no column leg,
  // or the hop cap reached
  assign hop_last = (hop_count == trxw_pkg::CNT_W'(trxw_pkg::MAX_RESULTS - 1))
                 || (seg_end && (y_phase || (srow == drow)));

  // Node ids, taken modulo 256
  assign srow_prod = PROD_W'(srow) * PROD_W'(ring_width);
  assign cur_prod  = PROD_W'(cur) * PROD_W'(ring_width);
  assign nxt_prod  = PROD_W'(nxt) * PROD_W'(ring_width);

  always_comb begin
    if (y_phase) begin
      from_id = IW'(cur_prod) + IW'(dcol);
      to_id   = IW'(nxt_prod) + IW'(dcol);
    end else begin
      from_id = row_base + IW'(cur);
      to_id   = row_base + IW'(nxt);
    end
  end

  //----------------------------------------------------------------------------
  // Walk registers
  //----------------------------------------------------------------------------
  assign slot_free = !hop_valid || !hop_stall;
  assign emit      = slot_free
                  && ((ctrl.op == trxw_pkg::OP_XHOP) || (ctrl.op == trxw_pkg::OP_YHOP));

  always_ff @(posedge clk) begin
    case (ctrl.op)
      trxw_pkg::OP_XSET: begin
        cur      <= scol;
        fwd      <= dir_fwd(scol, dcol, ring_width >> 1);
        row_base <= IW'(srow_prod);
      end
      trxw_pkg::OP_YSET: begin
        cur <= srow;
        fwd <= dir_fwd(srow, drow, ring_height >> 1);
      end
      trxw_pkg::OP_XHOP, trxw_pkg::OP_YHOP: begin
        if (emit) begin
          cur <= nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_count <= '0;
    end else if (ctrl.op == trxw_pkg::OP_START) begin
      hop_count <= '0;
    end else if (emit) begin
      hop_count <= hop_count + 1'b1;
    end
  end

  //----------------------------------------------------------------------------
  // Hop output register: load a beat whenever the slot is empty or draining
  //----------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hop_valid <= 1'b0;
    end else if (emit) begin
      hop_valid <= 1'b1;
    end else if (!hop_stall) begin
      hop_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hop.hop_from  <= from_id;
      hop.hop_to    <= to_id;
      hop.final_hop <= hop_last;
    end
  end

  //----------------------------------------------------------------------------
  // Sequencer
  //----------------------------------------------------------------------------
  assign status = '{
    req_fire:  req_fire,
    route_bad: route_bad,
    div_done:  div_done,
    x_equal:   (scol == dcol),
    y_equal:   (srow == drow),
    slot_free: slot_free,
    hop_last:  hop_last,
    seg_end:   seg_end
  };

  trxw_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  //----------------------------------------------------------------------------
  // Assertions
  //----------------------------------------------------------------------------
  `TRXW_ASSERT_NEXT(a_final_returns_idle, emit && hop_last, ctrl.op == trxw_pkg::OP_IDLE, "final hop did not return the program to idle")
  `TRXW_ASSERT_NEXT(a_accept_starts_check, req_fire, ctrl.op == trxw_pkg::OP_START, "accepted request did not reach the check step")
  `TRXW_ASSERT_NOW(a_row_leg_not_done, ctrl.op == trxw_pkg::OP_XHOP, cur != dcol, "row leg running at the target column")
  `TRXW_ASSERT_NOW(a_hop_cap, 1'b1, hop_count <= trxw_pkg::MAX_RESULTS, "hop count past the cap")

endmodule
